/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

/* sv/irn_pkg.sv */
// ----------------------------------------------------------------------------
// irn_pkg
// shared types and constants of the nearest-neighbor image rotator
// ----------------------------------------------------------------------------
package irn_pkg;

  localparam int MAX_SIDE     = 64;
  localparam int SIDE_BITS    = $clog2(MAX_SIDE);
  localparam int DIM_BITS     = SIDE_BITS + 1;
  localparam int ADDR_BITS    = 2 * SIDE_BITS;
  localparam int MEM_DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int FRAC_BITS    = 16;
  localparam int PIXEL_BITS   = 32;
  localparam int COEF_BITS    = 18;
  localparam int DELTA_BITS   = SIDE_BITS + 1;
  localparam int PROD_BITS    = COEF_BITS + DELTA_BITS;
  localparam int SUM_BITS     = PROD_BITS + 3;
  localparam int POS_BITS     = SUM_BITS - FRAC_BITS;
  localparam int HALF_FIX     = (5 << FRAC_BITS) / 10;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic [DIM_BITS-1:0]         dim_t;
  typedef logic [SIDE_BITS-1:0]        side_t;
  typedef logic [ADDR_BITS-1:0]        addr_t;
  typedef logic [PIXEL_BITS-1:0]       pixel_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3
  } cfg_reg_t;

  localparam coef_t COS_RESET = COEF_BITS'(1 << FRAC_BITS);
  localparam coef_t SIN_RESET = '0;
  localparam dim_t  DIM_RESET = DIM_BITS'(32);

  // one memory operation leaving the coordinate pipeline
  typedef struct packed {
    logic   valid;
    kind_t  kind;
    logic   in_img;
    addr_t  addr;
    pixel_t pixel;
  } mem_op_t;

  // size register clamped to the store's side
  function automatic dim_t eff_side(dim_t r);
    return (r > DIM_BITS'(MAX_SIDE)) ? DIM_BITS'(MAX_SIDE) : r;
  endfunction

endpackage

/* sv/irn_xform.sv */
// ----------------------------------------------------------------------------
// irn_xform
// three-stage coordinate pipeline: center, rotate, round and bound check
// ----------------------------------------------------------------------------
module irn_xform (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  irn_pkg::kind_t    in_kind,
  input  irn_pkg::side_t    in_x,
  input  irn_pkg::side_t    in_y,
  input  irn_pkg::pixel_t   in_pixel,
  input  irn_pkg::coef_t    cos_coef,
  input  irn_pkg::coef_t    sin_coef,
  input  irn_pkg::dim_t     w_eff,
  input  irn_pkg::dim_t     h_eff,
  output irn_pkg::mem_op_t  op
);
  import irn_pkg::*;
  `include "assert_macros.svh"

  // stage a: centered deltas
  logic                         a_valid;
  kind_t                        a_kind;
  addr_t                        a_addr;
  pixel_t                       a_pixel;
  logic signed [DELTA_BITS-1:0] a_dx;
  logic signed [DELTA_BITS-1:0] a_dy;

  // stage b: products
  logic                         b_valid;
  kind_t                        b_kind;
  addr_t                        b_addr;
  pixel_t                       b_pixel;
  logic signed [PROD_BITS-1:0]  b_xc;
  logic signed [PROD_BITS-1:0]  b_ys;
  logic signed [PROD_BITS-1:0]  b_yc;
  logic signed [PROD_BITS-1:0]  b_xs;

  side_t                        cx;
  side_t                        cy;
  logic signed [DELTA_BITS-1:0] dx;
  logic signed [DELTA_BITS-1:0] dy;
  logic signed [SUM_BITS-1:0]   off_x;
  logic signed [SUM_BITS-1:0]   off_y;
  logic signed [SUM_BITS-1:0]   m_sum;
  logic signed [SUM_BITS-1:0]   n_sum;
  logic signed [POS_BITS-1:0]   sx;
  logic signed [POS_BITS-1:0]   sy;
  logic                         in_img;
  mem_op_t                      op_next;

  assign cx = w_eff[DIM_BITS-1:1];
  assign cy = h_eff[DIM_BITS-1:1];
  assign dx = $signed({1'b0, in_x}) - $signed({1'b0, cx});
  assign dy = $signed({1'b0, in_y}) - $signed({1'b0, cy});

  always_ff @(posedge clk) begin
    a_kind  <= in_kind;
    a_addr  <= {in_y, in_x};
    a_pixel <= in_pixel;
    a_dx    <= dx;
    a_dy    <= dy;
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_kind  <= a_kind;
    b_addr  <= a_addr;
    b_pixel <= a_pixel;
    b_xc    <= a_dx * cos_coef;
    b_ys    <= a_dy * sin_coef;
    b_yc    <= a_dy * cos_coef;
    b_xs    <= a_dx * sin_coef;
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  // center offset plus rounding half
  assign off_x = $signed(SUM_BITS'({cx, {FRAC_BITS{1'b0}}}) + SUM_BITS'(HALF_FIX));
  assign off_y = $signed(SUM_BITS'({cy, {FRAC_BITS{1'b0}}}) + SUM_BITS'(HALF_FIX));
  assign m_sum = SUM_BITS'(b_xc) + SUM_BITS'(b_ys) + off_x;
  assign n_sum = SUM_BITS'(b_yc) - SUM_BITS'(b_xs) + off_y;

  // dropping the fraction bits is a floor on two's complement
  assign sx = $signed(m_sum[SUM_BITS-1:FRAC_BITS]);
  assign sy = $signed(n_sum[SUM_BITS-1:FRAC_BITS]) - $signed(POS_BITS'(1));

  assign in_img = (sx >= $signed(POS_BITS'(0))) && (sx < $signed(POS_BITS'(w_eff))) &&
                  (sy >= $signed(POS_BITS'(0))) && (sy < $signed(POS_BITS'(h_eff)));

  always_comb begin
    op_next.valid  = b_valid;
    op_next.kind   = b_kind;
    op_next.pixel  = b_pixel;
    op_next.in_img = 1'b0;
    op_next.addr   = b_addr;
    if (b_kind == KIND_QUERY) begin
      op_next.in_img = in_img;
      op_next.addr   = {sy[SIDE_BITS-1:0], sx[SIDE_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= '0;
    end else begin
      op <= op_next;
    end
  end

  `ASSERT_CLK(a_inside_col, clk, rst, op.valid && op.in_img |-> DIM_BITS'(op.addr[SIDE_BITS-1:0]) < w_eff, "inside sample column beyond width")
  `ASSERT_CLK(a_inside_row, clk, rst, op.valid && op.in_img |-> DIM_BITS'(op.addr[ADDR_BITS-1:SIDE_BITS]) < h_eff, "inside sample row beyond height")
  `ASSERT_NEVER(a_write_flag, clk, rst, op.kind == KIND_WRITE && op.in_img, "write word flagged inside")

endmodule

/* sv/image_rotate_nearest.sv */
// ----------------------------------------------------------------------------
// image_rotate_nearest
// nearest-neighbor image rotator around the image center, q16 coefficients
// ----------------------------------------------------------------------------
// result path: a query word passes stage registers a and b and the op register
//   before its result strobe (done) is registered; a write word gives no result
// throughput: one word per clock, busy stays low; the single memory port is
//   used once per word, writes and reads in acceptance order
// reset: pipeline and strobe cleared, registers back to defaults; the 4096-word
//   source store is not cleared, here the receiver cannot stall
// ----------------------------------------------------------------------------
module image_rotate_nearest (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  irn_pkg::kind_t                    kind,
  input  irn_pkg::side_t                    coord_x,
  input  irn_pkg::side_t                    coord_y,
  input  irn_pkg::pixel_t                   pixel_in,
  // result channel
  output logic                              done,
  output irn_pkg::pixel_t                   pixel_out,
  output logic                              inside_res,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irn_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [irn_pkg::COEF_BITS-1:0]     cfg_data
);
  import irn_pkg::*;
  `include "assert_macros.svh"

  // configuration registers
  coef_t   cos_coef;
  coef_t   sin_coef;
  dim_t    img_width;
  dim_t    img_height;
  dim_t    w_eff;
  dim_t    h_eff;

  logic    accept;
  mem_op_t op;

  // source store: one synchronous port, registered read data
  pixel_t  src_mem [MEM_DEPTH];
  pixel_t  rd_data;

  // the pipeline never stalls, so a word is taken every cycle
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // register file, unknown indexes fall through untouched
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_coef   <= COS_RESET;
      sin_coef   <= SIN_RESET;
      img_width  <= DIM_RESET;
      img_height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COS:    cos_coef   <= $signed(cfg_data);
        REG_SIN:    sin_coef   <= $signed(cfg_data);
        REG_WIDTH:  img_width  <= cfg_data[DIM_BITS-1:0];
        REG_HEIGHT: img_height <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sizes above the store's side behave as the full side
  assign w_eff = eff_side(img_width);
  assign h_eff = eff_side(img_height);

  // center, rotate, round and bound check over three stages
  irn_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_kind  (kind),
    .in_x     (coord_x),
    .in_y     (coord_y),
    .in_pixel (pixel_in),
    .cos_coef (cos_coef),
    .sin_coef (sin_coef),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .op       (op)
  );

  // writes and reads hit the store at the same pipeline depth, so order holds
  always_ff @(posedge clk) begin
    if (op.valid && op.kind == KIND_WRITE) begin
      src_mem[op.addr] <= op.pixel;
    end
    rd_data <= src_mem[op.addr];
  end

  // result strobe and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      inside_res <= 1'b0;
    end else begin
      done       <= op.valid && op.kind == KIND_QUERY;
      inside_res <= op.valid && op.kind == KIND_QUERY && op.in_img;
    end
  end

  // outside samples read as zero
  assign pixel_out = inside_res ? rd_data : '0;

  `ASSERT_CLK(a_done_from_query, clk, rst, done |-> $past(accept && kind == KIND_QUERY, 4), "result without a query four cycles back")
  `ASSERT_CLK(a_flag_with_done, clk, rst, inside_res |-> done, "inside flag outside a result cycle")
  `ASSERT_CLK(a_write_silent, clk, rst, op.valid && op.kind == KIND_WRITE |=> !done, "write word produced a result")

endmodule
